### design/msa_identity_sequence_weighting_core_assert.svh
// Assertion macros shared by the checker of the sequence weighting core.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef MSA_IDENTITY_SEQUENCE_WEIGHTING_CORE_ASSERT_SVH
`define MSA_IDENTITY_SEQUENCE_WEIGHTING_CORE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define MSA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another one at the following edge.
`define MSA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### design/msa_isw_pkg.sv
// Package of the sequence weighting core: item types, codes and helpers.
// Used by the core, its divider and its checker.
`timescale 1ns / 1ps

package msa_isw_pkg;

    // Store dimensions
    localparam int MAX_SEQS = 1024;
    localparam int MAX_LEN  = 512;
    localparam int IDX_W    = $clog2(MAX_SEQS);
    localparam int POS_W    = $clog2(MAX_LEN);
    localparam int LEN_W    = 10;
    localparam int CNT_W    = 11;
    localparam int WGT_W    = 17;
    localparam int NEFF_W   = 27;

    // Operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADCHAR = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_NOTCOMP = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SEQ_LENGTH    = 2'd0;
    localparam logic [1:0] CFG_MIN_IDENTICAL = 2'd1;
    localparam logic [1:0] CFG_COUNT_TARGET  = 2'd2;

    // Residue codes
    localparam logic [4:0] GAP_CODE = 5'd20;
    localparam logic [4:0] NO_CODE  = 5'd31;

    // One in Q1.16
    localparam logic [WGT_W-1:0] WEIGHT_ONE = 17'h10000;

    // Codes for 'A'..'Z'; NO_CODE never appears since every letter maps
    localparam logic [4:0] LETTER_CODE [26] = '{
        5'd0, 5'd20, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd20, 5'd8, 5'd9, 5'd10,
        5'd11, 5'd20, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd20, 5'd17, 5'd18, 5'd20,
        5'd19, 5'd20
    };

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] residue_char;
        logic [9:0] seq_index;
    } req_item_t;

    typedef struct packed {
        logic [WGT_W-1:0]  weight;
        logic [CNT_W-1:0]  neighbour_count;
        logic [NEFF_W-1:0] neff;
        logic [CNT_W-1:0]  seq_count;
        logic [2:0]        status;
    } rsp_item_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [WGT_W-1:0] quotient;
    } div_rsp_t;

    // Case-fold a character and map it to its residue code.
    function automatic logic [4:0] map_residue(input logic [7:0] ch);
        logic [7:0] c;
        c = ch;
        if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'd32;
        end
        if (c >= 8'h41 && c <= 8'h5A) begin
            return LETTER_CODE[5'(c - 8'h41)];
        end
        // Dash, dot and tilde are gaps
        if (c == 8'h2D || c == 8'h2E || c == 8'h7E) begin
            return GAP_CODE;
        end
        return NO_CODE;
    endfunction

    // Length in use: zero acts as one, anything above MAX_LEN is clipped to MAX_LEN.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        if (len == '0) begin
            return LEN_W'(1);
        end
        if (len > LEN_W'(MAX_LEN)) begin
            return LEN_W'(MAX_LEN);
        end
        return len;
    endfunction

endpackage

### design/msa_isw_div.sv
// Restoring divider that forms 1.0 in Q1.16 divided by a neighbour count.
// One quotient bit per cycle; depends on msa_isw_pkg.
`timescale 1ns / 1ps

module msa_isw_div
    import msa_isw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [4:0]       step_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] dsr_reg;
    logic [WGT_W-1:0] quo_reg;
    logic [CNT_W:0]   shifted;

    assign shifted = {rem_reg, quo_reg[WGT_W-1]};

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 5'(WGT_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 5'd1;
                if (step_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient; a zero count divides as one
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= WEIGHT_ONE;
            dsr_reg <= (req.divisor == '0) ? CNT_W'(1) : req.divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_reg <= CNT_W'(shifted - {1'b0, dsr_reg});
                quo_reg <= {quo_reg[WGT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[CNT_W-1:0];
                quo_reg <= {quo_reg[WGT_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### design/msa_identity_sequence_weighting_core.sv
// Top level of the sequence weighting core: residue store, neighbour counts,
// pair sweep sequencer and result queue. Depends on msa_isw_pkg and msa_isw_div.
//
// Usage. Items enter on req (req_valid / req_stall) and one result item per
// input item leaves on rsp (rsp_valid / rsp_stall), in order.
// Load (op 0) and clear (op 3) items finish in the accept cycle and their
// result is visible in the next cycle; loads stream at one item per cycle while the queue has room.
// A valid read (op 2) does one count memory read and then the 17 divider steps.
// Compute (op 1) sweeps all pairs of stored sequences, leaving out the first
// sequence when the count target is zero; the pair scan reads both sequences
// through the two read ports of the residue memory, one position a cycle, and
// the weight sum runs each count through the shared divider.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once and
// are meant for an idle block.
// Reset empties the store and clears the computed flag; the memories keep
// their contents and need no clearing pass.
// A two-entry result queue lets the block take items while a result waits;
// when both entries are full, req_stall rises until rsp_stall drops.
`timescale 1ns / 1ps

module msa_identity_sequence_weighting_core
    import msa_isw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_item_t        req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_item_t        rsp,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [LEN_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_ROW, S_ROWLD, S_PAIR, S_SCAN, S_DRAIN, S_DECIDE,
        S_JWR, S_ROWEND, S_SUMRD, S_SUMDIV, S_SUMWAIT, S_RDDIV, S_RDWAIT
    } state_t;

    state_t state_reg;

    // Configuration
    logic [LEN_W-1:0] seq_length_reg;
    logic [LEN_W-1:0] min_identical_reg;
    logic             count_target_reg;

    // Store status
    logic [CNT_W-1:0]  stored_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [NEFF_W-1:0] weight_sum_reg;
    logic              computed_reg;

    // Sweep registers
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] k_reg;
    logic [LEN_W-1:0] s_reg;
    logic [LEN_W-1:0] match_reg;
    logic [CNT_W-1:0] cnt_i_reg;
    logic             hit_reg;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    // Memories
    logic [4:0]       res_mem [MAX_SEQS*MAX_LEN];
    logic [4:0]       res_a_reg;
    logic [4:0]       res_b_reg;
    logic [CNT_W-1:0] cnt_mem [MAX_SEQS];
    logic [CNT_W-1:0] cnt_rdata_reg;

    logic             cnt_we;
    logic [IDX_W-1:0] cnt_waddr;
    logic [IDX_W-1:0] cnt_raddr;
    logic [CNT_W-1:0] cnt_wdata;

    // Result queue
    rsp_item_t  fifo_reg [2];
    logic [1:0] fifo_cnt_reg;
    logic       push;
    rsp_item_t  push_data;
    logic       pop;

    // Divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Load decode
    logic [LEN_W-1:0] len_w;
    logic [4:0]       ld_code;
    logic             ld_bad;
    logic             ld_full;
    logic             ld_last;
    logic             accept;
    logic             ld_ok;
    logic             excl_zero;

    assign len_w   = eff_len(seq_length_reg);
    assign ld_code = map_residue(req.residue_char);
    assign ld_bad  = (ld_code == NO_CODE);
    assign ld_full = (stored_reg == CNT_W'(MAX_SEQS));
    assign ld_last = (({1'b0, pos_reg} + LEN_W'(1)) >= len_w);
    assign accept  = req_valid && !req_stall;
    assign ld_ok   = accept && (req.op == OP_LOAD) && !ld_bad && !ld_full;
    assign pop     = rsp_valid && !rsp_stall;

    assign req_stall = (state_reg != S_IDLE) || (fifo_cnt_reg == 2'd2);
    assign rsp_valid = (fifo_cnt_reg != 2'd0);
    assign rsp       = fifo_reg[0];

    // The excluded first sequence reads weight zero
    assign excl_zero = !count_target_reg && (rd_idx_reg == '0);

    // Count memory port and divider start selection
    always_comb
    begin
        cnt_raddr       = req.seq_index;
        cnt_we          = 1'b0;
        cnt_waddr       = i_reg[IDX_W-1:0];
        cnt_wdata       = cnt_i_reg;
        div_req.start   = 1'b0;
        div_req.divisor = cnt_rdata_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = k_reg[IDX_W-1:0];
                cnt_wdata = CNT_W'(1);
            end
            S_ROW:    cnt_raddr = i_reg[IDX_W-1:0];
            S_DECIDE: cnt_raddr = j_reg[IDX_W-1:0];
            S_JWR:
            begin
                cnt_we    = hit_reg;
                cnt_waddr = j_reg[IDX_W-1:0];
                cnt_wdata = cnt_rdata_reg + CNT_W'(1);
            end
            S_ROWEND: cnt_we = 1'b1;
            S_SUMRD:  cnt_raddr = k_reg[IDX_W-1:0];
            S_SUMDIV: div_req.start = 1'b1;
            S_RDDIV:  div_req.start = 1'b1;
            default:  ;
        endcase
    end

    // Result item formation
    always_comb
    begin
        push                      = 1'b0;
        push_data.weight          = '0;
        push_data.neighbour_count = '0;
        push_data.neff            = computed_reg ? weight_sum_reg : '0;
        push_data.seq_count       = stored_reg;
        push_data.status          = ST_OK;
        if (state_reg == S_IDLE && accept)
        begin
            unique case (req.op)
                OP_LOAD:
                begin
                    push = 1'b1;
                    if (ld_bad)
                    begin
                        push_data.status = ST_BADCHAR;
                    end
                    else if (ld_full)
                    begin
                        push_data.status = ST_FULL;
                    end
                    else
                    begin
                        push_data.neff = '0;
                        if (ld_last)
                        begin
                            push_data.seq_count = stored_reg + CNT_W'(1);
                        end
                    end
                end
                OP_COMPUTE: push = 1'b0;
                OP_READ:
                begin
                    if (!computed_reg)
                    begin
                        push             = 1'b1;
                        push_data.status = ST_NOTCOMP;
                    end
                    else if ({1'b0, req.seq_index} >= stored_reg)
                    begin
                        push             = 1'b1;
                        push_data.status = ST_RANGE;
                    end
                end
                OP_CLEAR:
                begin
                    push                = 1'b1;
                    push_data.neff      = '0;
                    push_data.seq_count = '0;
                end
                default: ;
            endcase
        end
        else if (state_reg == S_SUMRD && k_reg >= stored_reg)
        begin
            push           = 1'b1;
            push_data.neff = weight_sum_reg;
        end
        else if (state_reg == S_RDWAIT && div_rsp.done)
        begin
            push                      = 1'b1;
            push_data.weight          = excl_zero ? '0 : div_rsp.quotient;
            push_data.neighbour_count = cnt_i_reg;
        end
    end

    // Residue store: one write port for loads, two read ports for the pair scan
    always_ff @(posedge clk)
    begin
        if (ld_ok)
        begin
            res_mem[{stored_reg[IDX_W-1:0], pos_reg}] <= ld_code;
        end
        res_a_reg <= res_mem[{i_reg[IDX_W-1:0], s_reg[POS_W-1:0]}];
        res_b_reg <= res_mem[{j_reg[IDX_W-1:0], s_reg[POS_W-1:0]}];
    end

    // Neighbour count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    // Result queue of two entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (pop && push)
            begin
                if (fifo_cnt_reg == 2'd1)
                begin
                    fifo_reg[0] <= push_data;
                end
                else
                begin
                    fifo_reg[0] <= fifo_reg[1];
                    fifo_reg[1] <= push_data;
                end
            end
            else if (pop)
            begin
                fifo_reg[0]  <= fifo_reg[1];
                fifo_cnt_reg <= fifo_cnt_reg - 2'd1;
            end
            else if (push)
            begin
                fifo_reg[fifo_cnt_reg[0]] <= push_data;
                fifo_cnt_reg              <= fifo_cnt_reg + 2'd1;
            end
        end
    end

    // Sequencer and store status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            seq_length_reg    <= LEN_W'(512);
            min_identical_reg <= LEN_W'(409);
            count_target_reg  <= 1'b0;
            stored_reg        <= '0;
            pos_reg           <= '0;
            weight_sum_reg    <= '0;
            computed_reg      <= 1'b0;
            i_reg             <= '0;
            j_reg             <= '0;
            k_reg             <= '0;
            s_reg             <= '0;
            match_reg         <= '0;
            cnt_i_reg         <= '0;
            hit_reg           <= 1'b0;
            cmp_valid_reg     <= 1'b0;
            rd_idx_reg        <= '0;
        end
        else
        begin
            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_SEQ_LENGTH:    seq_length_reg    <= cfg_wdata;
                    CFG_MIN_IDENTICAL: min_identical_reg <= cfg_wdata;
                    CFG_COUNT_TARGET:  count_target_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end

            // Match accumulation in the cycle after the scan reads
            cmp_valid_reg <= (state_reg == S_SCAN);
            if (cmp_valid_reg && res_a_reg == res_b_reg)
            begin
                match_reg <= match_reg + LEN_W'(1);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (req.op)
                            OP_LOAD:
                            begin
                                if (ld_ok)
                                begin
                                    computed_reg   <= 1'b0;
                                    weight_sum_reg <= '0;
                                    if (ld_last)
                                    begin
                                        pos_reg    <= '0;
                                        stored_reg <= stored_reg + CNT_W'(1);
                                    end
                                    else
                                    begin
                                        pos_reg <= pos_reg + POS_W'(1);
                                    end
                                end
                            end
                            OP_COMPUTE:
                            begin
                                computed_reg   <= 1'b0;
                                weight_sum_reg <= '0;
                                k_reg          <= '0;
                                state_reg      <= (stored_reg == '0) ? S_SUMRD : S_INIT;
                            end
                            OP_READ:
                            begin
                                rd_idx_reg <= req.seq_index;
                                if (computed_reg && {1'b0, req.seq_index} < stored_reg)
                                begin
                                    state_reg <= S_RDDIV;
                                end
                            end
                            OP_CLEAR:
                            begin
                                stored_reg     <= '0;
                                pos_reg        <= '0;
                                weight_sum_reg <= '0;
                                computed_reg   <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                // Every stored sequence starts as its own neighbour
                S_INIT:
                begin
                    if (k_reg + CNT_W'(1) >= stored_reg)
                    begin
                        i_reg     <= count_target_reg ? CNT_W'(0) : CNT_W'(1);
                        state_reg <= S_ROW;
                    end
                    else
                    begin
                        k_reg <= k_reg + CNT_W'(1);
                    end
                end
                S_ROW:
                begin
                    if (i_reg + CNT_W'(1) >= stored_reg)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_SUMRD;
                    end
                    else
                    begin
                        j_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_ROWLD;
                    end
                end
                S_ROWLD:
                begin
                    cnt_i_reg <= cnt_rdata_reg;
                    state_reg <= S_PAIR;
                end
                S_PAIR:
                begin
                    s_reg     <= '0;
                    match_reg <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    s_reg <= s_reg + LEN_W'(1);
                    if (s_reg + LEN_W'(1) >= len_w)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    hit_reg <= (match_reg > min_identical_reg);
                    if (match_reg > min_identical_reg)
                    begin
                        cnt_i_reg <= cnt_i_reg + CNT_W'(1);
                    end
                    state_reg <= S_JWR;
                end
                S_JWR:
                begin
                    if (j_reg + CNT_W'(1) < stored_reg)
                    begin
                        j_reg     <= j_reg + CNT_W'(1);
                        state_reg <= S_PAIR;
                    end
                    else
                    begin
                        state_reg <= S_ROWEND;
                    end
                end
                S_ROWEND:
                begin
                    i_reg     <= i_reg + CNT_W'(1);
                    state_reg <= S_ROW;
                end
                // Weight sum over the stored sequences, without the first when the count target is zero
                S_SUMRD:
                begin
                    if (k_reg >= stored_reg)
                    begin
                        computed_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SUMDIV;
                    end
                end
                S_SUMDIV: state_reg <= S_SUMWAIT;
                S_SUMWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (count_target_reg || k_reg != '0)
                        begin
                            weight_sum_reg <= weight_sum_reg + NEFF_W'(div_rsp.quotient);
                        end
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= S_SUMRD;
                    end
                end
                // Single weight read
                S_RDDIV:
                begin
                    cnt_i_reg <= cnt_rdata_reg;
                    state_reg <= S_RDWAIT;
                end
                S_RDWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    msa_isw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

### design/msa_isw_checker.sv
// Port-level checker of the sequence weighting core, bound to the top level.
// Depends on msa_isw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "msa_identity_sequence_weighting_core_assert.svh"

module msa_isw_checker
    import msa_isw_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_stall,
    input req_item_t        req,
    input logic             rsp_valid,
    input logic             rsp_stall,
    input rsp_item_t        rsp,
    input logic             cfg_we,
    input logic [1:0]       cfg_addr,
    input logic [LEN_W-1:0] cfg_wdata
);

    // A stalled result item holds
    `MSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")

    // Failed items carry no weight and no count
    `MSA_ASSERT_ALWAYS(a_err_empty, !rsp_valid || rsp.status == ST_OK || (rsp.weight == '0 && rsp.neighbour_count == '0), "error item carries data")

    // A nonzero weight always comes with a neighbour count
    `MSA_ASSERT_ALWAYS(a_wgt_cnt, !rsp_valid || rsp.weight == '0 || rsp.neighbour_count != '0, "weight without count")

    // The store never reports more sequences than its capacity
    `MSA_ASSERT_ALWAYS(a_seq_max, !rsp_valid || rsp.seq_count <= CNT_W'(MAX_SEQS), "seq_count beyond capacity")

endmodule

bind msa_identity_sequence_weighting_core msa_isw_checker u_checker (.*);
